>>> design/vrsc_pkg.sv
// vrsc_pkg: shared widths, register indexes, route state type and saturating adders
// for the vehicle route split cost unit; depends on nothing
package vrsc_pkg;

  localparam int DemW     = 16;
  localparam int DistW    = 32;
  localparam int LimW     = 31;
  localparam int CapW     = 16;
  localparam int SpaceW   = 18;
  localparam int TripW    = 48;
  localparam int CostW    = 47;
  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = 31;
  localparam int InDataW  = DemW + 4 * DistW;
  localparam int OutDataW = 48;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_CAPACITY   = 2'd0,
    CFG_LIMIT_EN   = 2'd1,
    CFG_DIST_LIMIT = 2'd2
  } cfg_idx_t;

  typedef struct packed {
    logic signed [SpaceW-1:0] space_left;
    logic [TripW-1:0]         trip;
    logic [CostW-1:0]         total;
    logic                     err;
    logic                     in_route;
  } route_state_t;

  // trip distance plus one leg, clamped to the trip width
  function automatic logic [TripW-1:0] sat_trip(input logic [TripW-1:0] a,
                                               input logic [LimW-1:0] b);
    logic [TripW:0] s;
    s = {1'b0, a} + (TripW+1)'(b);
    return s[TripW] ? {TripW{1'b1}} : s[TripW-1:0];
  endfunction

  // route cost plus a finished trip, clamped to the cost width
  function automatic logic [CostW-1:0] sat_cost(input logic [CostW-1:0] a,
                                               input logic [TripW-1:0] b);
    logic [TripW:0] s;
    s = {2'b00, a} + {1'b0, b};
    return (s[TripW] | s[TripW-1]) ? {CostW{1'b1}} : s[CostW-1:0];
  endfunction

endpackage

>>> design/vrsc_step.sv
// vrsc_step: per-customer route update, depot returns and missing edge detection
// depends on vrsc_pkg
module vrsc_step (
  input  logic [vrsc_pkg::CapW-1:0]          capacity,
  input  logic                               limit_enabled,
  input  logic [vrsc_pkg::LimW-1:0]          distance_limit,
  input  vrsc_pkg::route_state_t             st,
  input  logic [vrsc_pkg::DemW-1:0]          demand,
  input  logic signed [vrsc_pkg::DistW-1:0]  dist_prev_to_node,
  input  logic signed [vrsc_pkg::DistW-1:0]  dist_depot_to_node,
  input  logic signed [vrsc_pkg::DistW-1:0]  dist_node_to_depot,
  input  logic signed [vrsc_pkg::DistW-1:0]  dist_prev_to_depot,
  input  logic                               last_in_route,
  output vrsc_pkg::route_state_t             nxt
);
  import vrsc_pkg::*;

  logic                     first;
  logic signed [SpaceW-1:0] sl_e;
  logic [TripW-1:0]         trip_e;
  logic [CostW-1:0]         tot_e;
  logic                     err_e;
  logic [SpaceW:0]          diff;
  logic                     ret1, at1, ret2, at2, ret_far, over, fail;
  logic [DistW-1:0]         d1;
  logic [DistW-1:0]         sum_dep;
  logic [TripW+1:0]         sum_far;
  logic [CostW-1:0]         tot_ret;
  logic [SpaceW-1:0]        sl_base;

  always_comb begin
    first   = !st.in_route;
    sl_e    = first ? SpaceW'(capacity) : st.space_left;
    trip_e  = first ? '0 : st.trip;
    tot_e   = first ? '0 : st.total;
    err_e   = first ? 1'b0 : st.err;
    // capacity check
    diff    = {sl_e[SpaceW-1], sl_e} - (SpaceW+1)'(demand);
    ret1    = diff[SpaceW];
    at1     = first | ret1;
    d1      = at1 ? dist_depot_to_node : dist_prev_to_node;
    // distance limit check, from the depot or from the previous stop
    sum_dep = DistW'(dist_depot_to_node[LimW-1:0]) + DistW'(dist_node_to_depot[LimW-1:0]);
    sum_far = (TripW+2)'(trip_e) + (TripW+2)'(dist_prev_to_node[LimW-1:0])
            + (TripW+2)'(dist_node_to_depot[LimW-1:0]);
    over    = at1 ? (sum_dep > DistW'(distance_limit))
                  : (sum_far > (TripW+2)'(distance_limit));
    ret2    = limit_enabled & over;
    at2     = at1 | ret2;
    ret_far = (ret1 & !first) | (ret2 & !at1);
    tot_ret = sat_cost(tot_e, sat_trip(trip_e, dist_prev_to_depot[LimW-1:0]));
    fail    = (ret_far & dist_prev_to_depot[DistW-1])
            | d1[DistW-1]
            | (limit_enabled & dist_node_to_depot[DistW-1])
            | (ret2 & dist_depot_to_node[DistW-1])
            | (last_in_route & dist_node_to_depot[DistW-1]);
    sl_base = (ret1 | ret2) ? SpaceW'(capacity) : sl_e;

    nxt.space_left = sl_base - SpaceW'(demand);
    nxt.trip       = at2 ? TripW'(dist_depot_to_node[LimW-1:0])
                         : sat_trip(trip_e, dist_prev_to_node[LimW-1:0]);
    nxt.total      = ret_far ? tot_ret : tot_e;
    nxt.err        = err_e | fail;
    nxt.in_route   = !last_in_route;
  end

endmodule

>>> design/vehicle_route_split_cost_unit.sv
// vehicle_route_split_cost_unit: top level, config registers, route state and result stages
// depends on vrsc_pkg and vrsc_step
// one customer transfer accepted per cycle while in_tready is high; the route state loops through one register
// a last customer's result is held in the pending stage, then passes the final return add into the output stage
// output backpressure stalls the input only once both result stages are full
// reset: synchronous active low, clears config registers, route state and valid flags
module vehicle_route_split_cost_unit (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // demand, dist_prev_to_node, dist_depot_to_node, dist_node_to_depot, dist_prev_to_depot
  input  logic [vrsc_pkg::InDataW-1:0]       in_tdata,
  input  logic                               in_tlast,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // route_cost, zero pad
  output logic [vrsc_pkg::OutDataW-1:0]      out_tdata,
  // failed
  output logic [0:0]                         out_tuser,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [vrsc_pkg::CfgIdxW-1:0]       cfg_index,
  input  logic [vrsc_pkg::CfgDataW-1:0]      cfg_data
);
  import vrsc_pkg::*;

  logic [CapW-1:0]  cap_r;
  logic             lim_en_r;
  logic [LimW-1:0]  lim_r;
  route_state_t     st_r, st_nxt;
  logic             p_valid_r, p_valid_nxt;
  logic [CostW-1:0] p_total_r;
  logic [TripW-1:0] p_trip_r;
  logic [LimW-1:0]  p_ntd_r;
  logic             p_fail_r;
  logic             out_valid_r, out_valid_nxt;
  logic [CostW-1:0] out_cost_r, cost_nxt;
  logic             out_fail_r;
  logic             in_acc, p_adv;

  assign cfg_ready  = 1'b1;
  assign p_adv      = p_valid_r & (!out_valid_r | out_tready);
  assign in_tready  = !p_valid_r | p_adv;
  assign in_acc     = in_tvalid & in_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = OutDataW'(out_cost_r);
  assign out_tuser  = out_fail_r;

  vrsc_step u_step (
    .capacity           (cap_r),
    .limit_enabled      (lim_en_r),
    .distance_limit     (lim_r),
    .st                 (st_r),
    .demand             (in_tdata[DemW-1:0]),
    .dist_prev_to_node  (in_tdata[DemW+DistW-1:DemW]),
    .dist_depot_to_node (in_tdata[DemW+2*DistW-1:DemW+DistW]),
    .dist_node_to_depot (in_tdata[DemW+3*DistW-1:DemW+2*DistW]),
    .dist_prev_to_depot (in_tdata[DemW+4*DistW-1:DemW+3*DistW]),
    .last_in_route      (in_tlast),
    .nxt                (st_nxt)
  );

  always_comb begin
    p_valid_nxt = p_valid_r;
    if (in_acc && in_tlast) begin
      p_valid_nxt = 1'b1;
    end else if (p_adv) begin
      p_valid_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (p_adv) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
    cost_nxt = p_fail_r ? '0 : sat_cost(p_total_r, sat_trip(p_trip_r, p_ntd_r));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r       <= '0;
      lim_en_r    <= 1'b0;
      lim_r       <= '0;
      st_r        <= '0;
      p_valid_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          CFG_CAPACITY:   cap_r    <= cfg_data[CapW-1:0];
          CFG_LIMIT_EN:   lim_en_r <= cfg_data[0];
          CFG_DIST_LIMIT: lim_r    <= cfg_data[LimW-1:0];
          default: ;
        endcase
      end
      if (in_acc) begin
        st_r <= st_nxt;
      end
      p_valid_r   <= p_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && in_tlast) begin
      p_total_r <= st_nxt.total;
      p_trip_r  <= st_nxt.trip;
      p_ntd_r   <= in_tdata[DemW+2*DistW+LimW-1:DemW+2*DistW];
      p_fail_r  <= st_nxt.err;
    end
    if (p_adv) begin
      out_cost_r <= cost_nxt;
      out_fail_r <= p_fail_r;
    end
  end

`ifndef SYNTHESIS
  a_fail_zero_cost: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_fail_r |-> out_cost_r == '0)
    else $error("failed result with nonzero cost");

  a_pending_held: assert property (@(posedge clk) disable iff (!rst_n)
    p_valid_r && !p_adv |=> p_valid_r)
    else $error("pending result dropped");

  a_route_open: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> st_r.in_route == !$past(in_tlast))
    else $error("route open flag out of step with last marker");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !p_valid_r |-> in_tready)
    else $error("input stalled with empty pending stage");
`endif

endmodule

>>> dv/tb_top.sv
// tb_top: self-checking bench for vehicle_route_split_cost_unit, a directed table then random routes
// scored against a route cost predictor under random idling on both streams
// depends on vrsc_pkg and the design sources
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import vrsc_pkg::*;

  localparam int          RANDOM_ITEMS    = 1950;
  localparam int          SETTLE_CYCLES   = 8;
  localparam int          HOLD_OFF_CYCLES = 300;
  localparam int unsigned CYCLE_LIMIT     = 1_000_000;

  localparam logic [DistW-1:0]    NO_EDGE  = 32'h8000_0000;
  localparam logic [DistW-1:0]    MAX_LEG  = 32'h7fff_ffff;
  localparam longint unsigned     TRIP_MAX = (64'd1 << TripW) - 1;
  localparam longint unsigned     COST_MAX = (64'd1 << CostW) - 1;

  typedef struct {
    logic [DemW-1:0]  demand;
    logic [DistW-1:0] prev_to_node;
    logic [DistW-1:0] depot_to_node;
    logic [DistW-1:0] node_to_depot;
    logic [DistW-1:0] prev_to_depot;
    logic             route_end;
  } customer_t;

  typedef struct {
    logic [CostW-1:0] cost;
    logic             failed;
  } route_result_t;

  typedef struct {
    bit                  is_cfg;
    cfg_idx_t            reg_idx;
    logic [CfgDataW-1:0] reg_val;
    logic [DemW-1:0]     demand;
    logic [DistW-1:0]    ptn;
    logic [DistW-1:0]    dtn;
    logic [DistW-1:0]    ntd;
    logic [DistW-1:0]    ptd;
    bit                  route_end;
    bit                  typed;
    logic [CostW-1:0]    exp_cost;
    bit                  exp_fail;
  } plan_row_t;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [InDataW-1:0]    in_tdata;
  logic                  in_tlast;
  logic                  out_tvalid;
  logic                  out_tready;
  logic [OutDataW-1:0]   out_tdata;
  logic [0:0]            out_tuser;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CfgIdxW-1:0]    cfg_index;
  logic [CfgDataW-1:0]   cfg_data;

  // predictor copy of registers and route state
  int                    cap_reg;
  bit                    lim_on;
  longint unsigned       dist_lim;
  int                    load_left;
  longint unsigned       trip_len;
  longint unsigned       route_sum;
  bit                    err_flag;
  bit                    in_route;

  route_result_t         expected_costs[$];
  int                    mismatches;
  int                    random_sent;
  int unsigned           cycle_count;
  bit                    tx_calm;
  bit                    rx_calm;
  bit                    hold_off_req;

  plan_row_t plan [29] = '{
    '{0, CFG_CAPACITY, 0, 16'h0000, NO_EDGE, 32'h5_0000, 32'h7_0000, 32'h0, 1, 1, 47'hC_0000, 0},
    '{0, CFG_CAPACITY, 0, 16'hffff, 32'h0, MAX_LEG, MAX_LEG, NO_EDGE, 1, 1, 47'hFFFF_FFFE, 0},
    '{0, CFG_CAPACITY, 0, 16'h0000, 32'h0, NO_EDGE, 32'h1_0000, 32'h0, 1, 1, 47'h0, 1},
    '{0, CFG_CAPACITY, 0, 16'h0000, 32'h0, 32'h1_0000, 32'hffff_ffff, 32'h0, 1, 1, 47'h0, 1},
    '{0, CFG_CAPACITY, 0, 16'h0000, 32'h0, 32'h2_0000, NO_EDGE, 32'h0, 0, 0, 47'h0, 0},
    '{0, CFG_CAPACITY, 0, 16'h0000, 32'h3_0000, 32'h0, 32'h4_0000, 32'h0, 1, 1, 47'h9_0000, 0},
    '{0, CFG_CAPACITY, 0, 16'h0001, 32'h0, 32'h1_0000, 32'h1_0000, 32'h0, 0, 0, 47'h0, 0},
    '{0, CFG_CAPACITY, 0, 16'h0001, MAX_LEG, 32'h3_0000, 32'h5_0000, 32'h2_0000,
      1, 1, 47'hB_0000, 0},
    '{0, CFG_CAPACITY, 0, 16'h0005, 32'h0, 32'h1_0000, 32'h1_0000, 32'h0, 0, 0, 47'h0, 0},
    '{0, CFG_CAPACITY, 0, 16'h0005, 32'h1_0000, 32'h1_0000, 32'h1_0000, NO_EDGE,
      0, 0, 47'h0, 0},
    '{0, CFG_CAPACITY, 0, 16'h0000, 32'h1_0000, 32'h1_0000, 32'h1_0000, 32'h1_0000,
      1, 1, 47'h0, 1},
    '{0, CFG_CAPACITY, 0, 16'h0000, 32'h0, 32'h1_0000, 32'h1_0000, 32'h0, 1, 1, 47'h2_0000, 0},
    '{0, CFG_CAPACITY, 0, 16'h0000, 32'h0, 32'h1_0000, 32'h1_0000, 32'h0, 0, 0, 47'h0, 0},
    '{0, CFG_CAPACITY, 0, 16'h0000, NO_EDGE, 32'h1_0000, 32'h1_0000, 32'h0, 1, 1, 47'h0, 1},
    '{1, CFG_CAPACITY, 31'd10, 16'h0, 32'h0, 32'h0, 32'h0, 32'h0, 0, 0, 47'h0, 0},
    '{1, CFG_LIMIT_EN, 31'd1, 16'h0, 32'h0, 32'h0, 32'h0, 32'h0, 0, 0, 47'h0, 0},
    '{1, CFG_DIST_LIMIT, 31'h14_0000, 16'h0, 32'h0, 32'h0, 32'h0, 32'h0, 0, 0, 47'h0, 0},
    '{0, CFG_CAPACITY, 0, 16'h0004, 32'h0, 32'h5_0000, 32'h5_0000, 32'h0, 0, 0, 47'h0, 0},
    '{0, CFG_CAPACITY, 0, 16'h0004, 32'h8_0000, 32'h6_0000, 32'h9_0000, 32'h4_0000,
      1, 0, 47'h0, 0},
    '{0, CFG_CAPACITY, 0, 16'h0004, 32'h0, 32'h5_0000, NO_EDGE, 32'h0, 0, 0, 47'h0, 0},
    '{0, CFG_CAPACITY, 0, 16'h0000, 32'h1_0000, 32'h1_0000, 32'h1_0000, 32'h1_0000,
      1, 1, 47'h0, 1},
    '{0, CFG_CAPACITY, 0, 16'h0004, 32'h0, 32'h5_0000, 32'h5_0000, 32'h0, 0, 0, 47'h0, 0},
    '{0, CFG_CAPACITY, 0, 16'h0004, 32'h8_0000, 32'h6_0000, 32'h9_0000, NO_EDGE,
      1, 1, 47'h0, 1},
    '{0, CFG_CAPACITY, 0, 16'd11, 32'h0, 32'h1_0000, 32'h1_0000, 32'h0, 0, 0, 47'h0, 0},
    '{0, CFG_CAPACITY, 0, 16'h0000, 32'h1_0000, 32'h3_0000, 32'h1_0000, 32'h2_0000,
      1, 0, 47'h0, 0},
    '{1, CFG_DIST_LIMIT, 31'h7fff_ffff, 16'h0, 32'h0, 32'h0, 32'h0, 32'h0, 0, 0, 47'h0, 0},
    '{1, CFG_CAPACITY, 31'hffff, 16'h0, 32'h0, 32'h0, 32'h0, 32'h0, 0, 0, 47'h0, 0},
    '{0, CFG_CAPACITY, 0, 16'hffff, 32'h0, MAX_LEG, MAX_LEG, 32'h0, 0, 0, 47'h0, 0},
    '{0, CFG_CAPACITY, 0, 16'h0000, MAX_LEG, 32'h0, MAX_LEG, MAX_LEG, 1, 0, 47'h0, 0}
  };

  vehicle_route_split_cost_unit DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  function automatic longint unsigned clamp_to(longint unsigned v, longint unsigned top);
    return (v > top) ? top : v;
  endfunction

  // closes the open trip at the depot; a return from the depot itself only refills
  function automatic bit return_to_depot(inout bit at_depot, input logic [DistW-1:0] back);
    if (!at_depot) begin
      if (back[DistW-1])
        return 1'b0;
      route_sum = clamp_to(route_sum + clamp_to(trip_len + back, TRIP_MAX), COST_MAX);
      trip_len  = 0;
      at_depot  = 1'b1;
    end
    load_left = cap_reg;
    return 1'b1;
  endfunction

  function automatic bit serve_customer(customer_t c, bit at_depot);
    logic [DistW-1:0] leg;
    int               dem;
    dem = c.demand;
    if (load_left - dem < 0)
      if (!return_to_depot(at_depot, c.prev_to_depot))
        return 1'b0;
    leg = at_depot ? c.depot_to_node : c.prev_to_node;
    if (leg[DistW-1])
      return 1'b0;
    if (lim_on) begin
      if (c.node_to_depot[DistW-1])
        return 1'b0;
      if (trip_len + leg + c.node_to_depot > dist_lim) begin
        if (!return_to_depot(at_depot, c.prev_to_depot))
          return 1'b0;
        leg = c.depot_to_node;
        if (leg[DistW-1])
          return 1'b0;
      end
    end
    trip_len  = clamp_to(trip_len + leg, TRIP_MAX);
    load_left = load_left - dem;
    if (c.route_end) begin
      if (c.node_to_depot[DistW-1])
        return 1'b0;
      route_sum = clamp_to(route_sum + clamp_to(trip_len + c.node_to_depot, TRIP_MAX), COST_MAX);
      trip_len  = 0;
    end
    return 1'b1;
  endfunction

  function automatic void advance_route(customer_t c);
    bit            opening;
    route_result_t res;
    opening = !in_route;
    if (opening) begin
      load_left = cap_reg;
      trip_len  = 0;
      route_sum = 0;
      err_flag  = 1'b0;
      in_route  = 1'b1;
    end
    if (!err_flag)
      if (!serve_customer(c, opening))
        err_flag = 1'b1;
    if (c.route_end) begin
      res.cost   = err_flag ? '0 : route_sum[CostW-1:0];
      res.failed = err_flag;
      expected_costs.push_back(res);
      in_route = 1'b0;
    end
  endfunction

  function automatic logic [DistW-1:0] pick_leg(bit noisy);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (noisy && r < 12)
      return {1'b1, 31'($urandom)};
    r = $urandom_range(0, 99);
    if (r < 70)
      return $urandom_range(0, 32'h40_0000);
    if (r < 90)
      return {1'b0, 31'($urandom)};
    if (r < 95)
      return '0;
    return MAX_LEG;
  endfunction

  function automatic logic [DemW-1:0] pick_demand();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60)
      return DemW'($urandom_range(0, cap_reg / 4 + 1));
    if (r < 90)
      return DemW'($urandom);
    if (r < 95)
      return '0;
    return '1;
  endfunction

  task automatic send_customer(input customer_t c);
    in_tvalid <= 1'b1;
    in_tdata  <= {c.prev_to_depot, c.node_to_depot, c.depot_to_node, c.prev_to_node, c.demand};
    in_tlast  <= c.route_end;
    do @(posedge clk); while (!in_tready);
    advance_route(c);
  endtask

  task automatic tx_pause();
    int n;
    n = 0;
    if (!tx_calm && $urandom_range(0, 99) < 35)
      n = ($urandom_range(0, 99) < 85) ? $urandom_range(1, 3) : $urandom_range(10, 40);
    if (n > 0) begin
      in_tvalid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  task automatic wait_idle();
    in_tvalid <= 1'b0;
    while (expected_costs.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [CfgDataW-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_CAPACITY:   cap_reg  = val[CapW-1:0];
      CFG_LIMIT_EN:   lim_on   = val[0];
      CFG_DIST_LIMIT: dist_lim = val;
      default: ;
    endcase
  endtask

  task automatic run_route(int len, bit noisy);
    customer_t c;
    for (int k = 0; k < len; k++) begin
      c.demand        = pick_demand();
      c.prev_to_node  = pick_leg(noisy);
      c.depot_to_node = pick_leg(noisy);
      c.node_to_depot = pick_leg(noisy);
      c.prev_to_depot = pick_leg(noisy);
      c.route_end     = (k == len - 1);
      tx_pause();
      send_customer(c);
      random_sent++;
    end
  endtask

  // receiver: random short and long stalls, plus a long hold-off on each request
  initial begin : rx_side
    int gap;
    int held;
    gap = 0;
    out_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        out_tready <= 1'b0;
        for (held = 0; held < HOLD_OFF_CYCLES; held++) @(posedge clk);
      end else if (gap > 0) begin
        out_tready <= 1'b0;
        gap--;
      end else begin
        out_tready <= 1'b1;
        if (!rx_calm && $urandom_range(0, 99) < 20)
          gap = ($urandom_range(0, 99) < 85) ? $urandom_range(1, 3) : $urandom_range(10, 40);
      end
    end
  end

  always @(posedge clk) begin : result_check
    route_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_costs.size() == 0) begin
        $error("unexpected result transfer: route_cost %0h failed %0b",
               out_tdata[CostW-1:0], out_tuser[0]);
        mismatches++;
      end else begin
        want = expected_costs.pop_front();
        if (out_tdata[CostW-1:0] !== want.cost) begin
          $error("route_cost: expected %0h, got %0h", want.cost, out_tdata[CostW-1:0]);
          mismatches++;
        end
        if (out_tdata[OutDataW-1:CostW] !== '0) begin
          $error("pad: expected 0, got %0h", out_tdata[OutDataW-1:CostW]);
          mismatches++;
        end
        if (out_tuser[0] !== want.failed) begin
          $error("failed: expected %0b, got %0b", want.failed, out_tuser[0]);
          mismatches++;
        end
      end
    end
  end

  initial begin : stimulus
    customer_t           c;
    logic [CfgDataW-1:0] cap_v;
    logic [CfgDataW-1:0] lim_v;
    bit                  en_v;
    int                  phase;
    int                  left;
    int                  len;
    int unsigned         r;
    in_tvalid    <= 1'b0;
    in_tdata     <= '0;
    in_tlast     <= 1'b0;
    cfg_valid    <= 1'b0;
    cfg_index    <= CFG_CAPACITY;
    cfg_data     <= '0;
    rst_n        <= 1'b0;
    cycle_count  = 0;
    mismatches   = 0;
    random_sent  = 0;
    tx_calm      = 1'b0;
    rx_calm      = 1'b0;
    hold_off_req = 1'b0;
    cap_reg      = 0;
    lim_on       = 1'b0;
    dist_lim     = 0;
    load_left    = 0;
    trip_len     = 0;
    route_sum    = 0;
    err_flag     = 1'b0;
    in_route     = 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (plan[i]) begin
      if (plan[i].is_cfg) begin
        wait_idle();
        write_reg(plan[i].reg_idx, plan[i].reg_val);
        cfg_valid <= 1'b0;
      end else begin
        c.demand        = plan[i].demand;
        c.prev_to_node  = plan[i].ptn;
        c.depot_to_node = plan[i].dtn;
        c.node_to_depot = plan[i].ntd;
        c.prev_to_depot = plan[i].ptd;
        c.route_end     = plan[i].route_end;
        tx_pause();
        send_customer(c);
        if (plan[i].typed)
          expected_costs[expected_costs.size() - 1] = '{plan[i].exp_cost, plan[i].exp_fail};
      end
    end

    phase = 0;
    while (random_sent < RANDOM_ITEMS) begin
      wait_idle();
      case ($urandom_range(0, 5))
        0:       cap_v = 0;
        1:       cap_v = 16'hffff;
        2:       cap_v = 16'($urandom);
        default: cap_v = $urandom_range(1, 300);
      endcase
      en_v = ($urandom_range(0, 99) < 60);
      case ($urandom_range(0, 5))
        0:       lim_v = 0;
        1:       lim_v = 31'h7fff_ffff;
        2:       lim_v = 31'($urandom);
        default: lim_v = $urandom_range(32'h10_0000, 32'h400_0000);
      endcase
      write_reg(CFG_CAPACITY, cap_v);
      write_reg(CFG_LIMIT_EN, CfgDataW'(en_v));
      write_reg(CFG_DIST_LIMIT, lim_v);
      cfg_valid <= 1'b0;
      tx_calm = ($urandom_range(0, 99) < 25);
      rx_calm = ($urandom_range(0, 99) < 25);
      if (phase == 0 || $urandom_range(0, 99) < 30)
        hold_off_req = 1'b1;
      left = $urandom_range(120, 260);
      while (left > 0) begin
        r = $urandom_range(0, 99);
        if (r < 70)
          len = $urandom_range(1, 8);
        else if (r < 95)
          len = $urandom_range(9, 30);
        else
          len = $urandom_range(31, 80);
        run_route(len, $urandom_range(0, 99) < 20);
        left -= len;
        // sender holds back until every outstanding route result is out
        if (phase == 1 || $urandom_range(0, 99) < 3) begin
          in_tvalid <= 1'b0;
          while (expected_costs.size() != 0) @(posedge clk);
        end
      end
      phase++;
    end

    in_tvalid <= 1'b0;
    while (expected_costs.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule

>>> sim.f
design/vrsc_pkg.sv
design/vrsc_step.sv
design/vehicle_route_split_cost_unit.sv
dv/tb_top.sv
